// File: sv/kfq_pkg.sv
// Shared types and codes for the keyed order queue.
package kfq_pkg;

	typedef enum logic [2:0] {
		KIND_ADD    = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_COUNT  = 3'd2,
		KIND_LIST   = 3'd3,
		KIND_POP    = 3'd4,
		KIND_CHANGE = 3'd5
	} kfq_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} kfq_status_t;

	typedef struct packed {
		logic [15:0] num;
		logic [31:0] tag;
		logic [15:0] wid;
	} kfq_entry_t;

endpackage

// File: sv/kfq_ram.sv
// Entry store: one write port, one read port, registered read data.
module kfq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  kfq_pkg::kfq_entry_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output kfq_pkg::kfq_entry_t rd_data
);
	import kfq_pkg::*;

	kfq_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/keyed_fifo_with_cancel_and_update.sv
// Keyed order queue: a circular buffer of order entries in one RAM, with
// in-place remove, change, list and pop. One operation word is taken at a
// time. Add and count send their result from the execute state; pop reads
// the head entry there and sends it from the pop state. List streams one
// entry per cycle while the output is free. Remove and change first walk
// every held entry through the single RAM read port, one per cycle, then
// send their results, one per cycle while the output is free. The store
// needs no clearing after reset.
module keyed_fifo_with_cancel_and_update #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // customer_tag[31:0], widget_count[47:32], order_id[63:48]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // order_id_res[15:0], customer_tag_res[47:16],
	                              // widget_count_res[63:48], pending_count[68:64], zero[71:69]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);
	import kfq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT,
		ST_LIST,
		ST_POP
	} state_t;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [AW:0] s;
		s = (AW+1)'(base) + (AW+1)'(off);
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	state_t      state_q;
	kfq_kind_t   kind_q;
	logic [31:0] tag_q;
	logic [15:0] wid_q;
	logic [15:0] id_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] total_q;
	logic [15:0] next_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] rem_q;
	logic        rd_v_s1;
	logic        rd_last_s1;
	logic [AW-1:0] rd_phys_s1;
	kfq_status_t em_status_q;
	logic [15:0] em_wid_q;
	logic [CW-1:0] em_pend_q;

	logic        out_valid_q;
	kfq_status_t out_status_q;
	logic [15:0] out_id_q;
	logic [31:0] out_tag_q;
	logic [15:0] out_wid_q;
	logic [4:0]  out_pend_q;
	logic        out_last_q;

	logic        out_free;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	kfq_entry_t  rd_data;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	kfq_entry_t  wr_data;
	logic        match;
	logic [CW-1:0] kept_n;
	logic [CW-1:0] n_n;

	kfq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_pend_q, out_wid_q, out_tag_q, out_id_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	assign match  = (rd_data.num == id_q);
	assign kept_n = kept_q + CW'((kind_q == KIND_REMOVE) && !match);
	assign n_n    = n_q + CW'(match);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = wrap_add(head_q, rd_idx_q);
		unique case (state_q)
			ST_EXEC: begin
				rd_en   = out_free && (kind_q == KIND_POP) && (total_q != '0);
				rd_addr = head_q;
			end
			ST_SCAN: begin
				rd_en = (rd_idx_q < total_q);
			end
			ST_LIST: begin
				rd_en = (rd_idx_q < total_q) && (!rd_v_s1 || out_free);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wrap_add(head_q, total_q);
		wr_data = '{num: next_q, tag: tag_q, wid: wid_q};
		if (state_q == ST_EXEC) begin
			wr_en = out_free && (kind_q == KIND_ADD) && (total_q != CW'(QUEUE_DEPTH));
		end else if (state_q == ST_SCAN && rd_v_s1) begin
			if (kind_q == KIND_REMOVE) begin
				wr_en   = !match;
				wr_addr = wrap_add(head_q, kept_q);
				wr_data = rd_data;
			end else begin
				wr_en   = match;
				wr_addr = rd_phys_s1;
				wr_data = '{num: rd_data.num, tag: rd_data.tag, wid: wid_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_ADD;
			tag_q        <= '0;
			wid_q        <= '0;
			id_q         <= '0;
			head_q       <= '0;
			total_q      <= '0;
			next_q       <= 16'd1;
			rd_idx_q     <= '0;
			kept_q       <= '0;
			n_q          <= '0;
			rem_q        <= '0;
			rd_v_s1      <= 1'b0;
			rd_last_s1   <= 1'b0;
			rd_phys_s1   <= '0;
			em_status_q  <= STAT_OK;
			em_wid_q     <= '0;
			em_pend_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STAT_OK;
			out_id_q     <= '0;
			out_tag_q    <= '0;
			out_wid_q    <= '0;
			out_pend_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= kfq_kind_t'(s_tuser);
						tag_q   <= s_tdata[31:0];
						wid_q   <= s_tdata[47:32];
						id_q    <= s_tdata[63:48];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						rd_idx_q     <= '0;
						kept_q       <= '0;
						n_q          <= '0;
						out_status_q <= STAT_OK;
						out_id_q     <= '0;
						out_tag_q    <= '0;
						out_wid_q    <= '0;
						out_pend_q   <= 5'(total_q);
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
						unique case (kind_q)
							KIND_ADD: begin
								out_valid_q <= 1'b1;
								if (total_q == CW'(QUEUE_DEPTH)) begin
									out_status_q <= STAT_FULL;
								end else begin
									out_id_q   <= next_q;
									out_pend_q <= 5'(total_q + CW'(1));
									total_q    <= total_q + CW'(1);
									next_q     <= (next_q == 16'hFFFF) ? 16'd1 : next_q + 16'd1;
								end
							end
							KIND_COUNT: begin
								out_valid_q <= 1'b1;
							end
							KIND_REMOVE, KIND_CHANGE, KIND_LIST, KIND_POP: begin
								if (total_q == '0) begin
									out_valid_q  <= 1'b1;
									out_status_q <= STAT_EMPTY;
								end else if (kind_q == KIND_LIST) begin
									state_q <= ST_LIST;
								end else if (kind_q == KIND_POP) begin
									state_q <= ST_POP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_idx_q   <= rd_idx_q + CW'(rd_en);
					rd_v_s1    <= rd_en;
					rd_phys_s1 <= rd_addr;
					rd_last_s1 <= (rd_idx_q + CW'(1) == total_q);
					if (rd_v_s1) begin
						kept_q <= kept_n;
						n_q    <= n_n;
						if (rd_last_s1) begin
							em_status_q <= (n_n == '0) ? STAT_NOT_FOUND : STAT_OK;
							em_wid_q    <= (n_n != '0 && kind_q == KIND_CHANGE) ? wid_q : 16'd0;
							rem_q       <= (n_n == '0) ? CW'(1) : n_n;
							if (kind_q == KIND_REMOVE) begin
								total_q   <= kept_n;
								em_pend_q <= kept_n;
							end else begin
								em_pend_q <= total_q;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= em_status_q;
						out_id_q     <= id_q;
						out_tag_q    <= '0;
						out_wid_q    <= em_wid_q;
						out_pend_q   <= 5'(em_pend_q);
						out_last_q   <= (rem_q == CW'(1));
						rem_q        <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LIST: begin
					rd_idx_q <= rd_idx_q + CW'(rd_en);
					if (rd_en) begin
						rd_v_s1    <= 1'b1;
						rd_last_s1 <= (rd_idx_q + CW'(1) == total_q);
					end else if (out_free) begin
						rd_v_s1 <= 1'b0;
					end
					if (rd_v_s1 && out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= STAT_OK;
						out_id_q     <= rd_data.num;
						out_tag_q    <= rd_data.tag;
						out_wid_q    <= rd_data.wid;
						out_pend_q   <= 5'(total_q);
						out_last_q   <= rd_last_s1;
						if (rd_last_s1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_POP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= STAT_OK;
						out_id_q     <= rd_data.num;
						out_tag_q    <= rd_data.tag;
						out_wid_q    <= rd_data.wid;
						out_pend_q   <= 5'(total_q - CW'(1));
						out_last_q   <= 1'b1;
						head_q       <= wrap_add(head_q, CW'(1));
						total_q      <= total_q - CW'(1);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same slot in one cycle");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP && out_free) |=> (total_q == $past(total_q) - CW'(1)))
		else $error("pop did not drop the entry count by one");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_v_s1)
		else $error("read stage still busy while idle");

endmodule
